### rtl/pfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared constants, types and arithmetic helpers of the perifocal state block.
// ----------------------------------------------------------------------------
package pfs_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int SQ_STEPS      = 64;
    localparam int DIV_U_STEPS   = 61;
    localparam int DIV_V_STEPS   = 63;

    localparam logic [63:0]  PI_Q60         = 64'h3243F6A8885A308D;
    localparam logic [63:0]  QUARTER_PI_Q60 = 64'h0C90FDAA22168C23;
    localparam logic [63:0]  ONE_Q60        = 64'h1000000000000000;
    localparam logic [49:0]  GM_RESET       = 50'd398600441800000;
    localparam logic [39:0]  SMA_RESET      = 40'd7000000;
    localparam logic [72:0]  MM_PER_M       = 73'd1000;

    typedef enum logic [1:0] {
        REG_GRAV_PARAM = 2'd0,
        REG_ECC        = 2'd1,
        REG_SMA        = 2'd2
    } t_reg;

    typedef struct packed {
        logic         busy;
        logic [39:0]  a;
        logic [23:0]  e;
        logic [60:0]  m;
        logic [102:0] num;
    } t_cfg;

    typedef struct packed {
        logic [63:0] ll;
        logic [63:0] lh;
        logic [63:0] hl;
        logic [63:0] hh;
    } t_pp;

    typedef struct packed {
        logic [67:0] rem;
        logic [63:0] root;
    } t_sq;

    typedef struct packed {
        logic [95:0] rem;
        logic [63:0] q;
    } t_dv;

    function automatic logic [63:0] atan_q60(input int i);
        logic [63:0] s;
        int k;
        int n;
        int den;
        s = '0;
        if (i == 0) begin
            return QUARTER_PI_Q60;
        end
        for (k = 0; k < 31; k++) begin
            n = i * (2 * k + 1);
            den = 2 * k + 1;
            if (n <= 60) begin
                if (k[0]) begin
                    s = s - ((64'd1 << (60 - n)) / 64'(den));
                end else begin
                    s = s + ((64'd1 << (60 - n)) / 64'(den));
                end
            end
        end
        return s;
    endfunction

    function automatic t_pp mul64(input logic [63:0] a, input logic [63:0] b);
        t_pp p;
        p.ll = 64'(a[31:0]) * 64'(b[31:0]);
        p.lh = 64'(a[31:0]) * 64'(b[63:32]);
        p.hl = 64'(a[63:32]) * 64'(b[31:0]);
        p.hh = 64'(a[63:32]) * 64'(b[63:32]);
        return p;
    endfunction

    function automatic logic [127:0] pp_sum(input t_pp p);
        return (128'(p.hh) << 64) + (128'(p.lh) << 32) + (128'(p.hl) << 32)
            + 128'(p.ll);
    endfunction

    function automatic logic [63:0] rnd_shr(input logic [127:0] v, input int n);
        logic [127:0] t;
        t = (v + (128'd1 << (n - 1))) >> n;
        return t[63:0];
    endfunction

    function automatic logic [63:0] sat_out(input logic [63:0] m, input logic neg,
                                            input int width);
        logic [63:0] lim;
        logic [63:0] r;
        lim = 64'd1 << (width - 1);
        if (neg) begin
            r = (m > lim) ? (64'd0 - lim) : (64'd0 - m);
        end else begin
            r = (m > lim - 64'd1) ? (lim - 64'd1) : m;
        end
        return r;
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic t_sq sqrt_step(input t_sq s, input logic [1:0] b);
        t_sq r;
        logic [67:0] t;
        logic [67:0] tr;
        t  = {s.rem[65:0], b};
        tr = {2'b00, s.root, 2'b01};
        if (t >= tr) begin
            r.rem  = t - tr;
            r.root = {s.root[62:0], 1'b1};
        end else begin
            r.rem  = t;
            r.root = {s.root[62:0], 1'b0};
        end
        return r;
    endfunction

    function automatic t_dv div_step(input t_dv s, input logic [95:0] d, input logic b);
        t_dv r;
        logic [95:0] t;
        t = {s.rem[94:0], b};
        if (t >= d) begin
            r.rem = t - d;
            r.q   = {s.q[62:0], 1'b1};
        end else begin
            r.rem = t;
            r.q   = {s.q[62:0], 1'b0};
        end
        return r;
    endfunction

endpackage

### rtl/perifocal_state_from_anomaly_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perifocal_state_from_anomaly_top
// Perifocal position and velocity of a Keplerian orbit from the eccentric
// anomaly, fully pipelined.
//
//   channel  | valid    | stall    | word
//   ---------+----------+----------+--------------------------------------
//   input    | i_valid  | o_stall  | i_ecc_anomaly
//   output   | o_valid  | i_stall  | o_pos_x o_pos_y o_vel_x o_vel_y o_invalid
//   config   | i_cfg_we | none     | i_cfg_index i_cfg_data
//
// One word enters per cycle while o_stall is low. Most of the pipeline depth
// lies in the bit-per-stage square root and the two dividers.
// After reset and after every register write the input stalls while the
// configuration sequencer derives sqrt(1-e^2) and sqrt(GM*a) one bit per
// cycle.
// A stalled output word freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module perifocal_state_from_anomaly_top import pfs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_ecc_anomaly,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [41:0] o_pos_x,
    output logic signed [41:0] o_pos_y,
    output logic signed [39:0] o_vel_x,
    output logic signed [39:0] o_vel_y,
    output logic               o_invalid,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [49:0]        i_cfg_data
);

    typedef struct packed {
        logic [41:0] posx;
        logic [41:0] posy;
        logic [63:0] as;
        logic [63:0] mc;
        logic        spos;
        logic        cneg;
        logic        cap;
    } t_vp;

    t_cfg               w_cfg;
    logic               w_en;
    logic               w_sc_valid;
    logic signed [63:0] w_cos;
    logic signed [63:0] w_sin;
    logic signed [63:0] w_cme;

    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en || w_cfg.busy;

    pfs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    pfs_sincos u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid && !w_cfg.busy),
        .i_ang   (i_ecc_anomaly),
        .o_valid (w_sc_valid),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    assign w_cme = w_cos - $signed({4'b0, w_cfg.e, 36'b0});

    logic        r_p1_v, r_p2_v, r_p3_v, r_p4_v;
    logic [63:0] r_p1_acme, r_p1_ac, r_p1_as;
    logic        r_p1_xneg, r_p1_cneg, r_p1_sneg, r_p1_spos;
    t_pp         r_p2_x, r_p2_ms, r_p2_ec, r_p2_mc;
    logic [63:0] r_p2_as;
    logic        r_p2_xneg, r_p2_cneg, r_p2_sneg, r_p2_spos;
    logic [41:0] r_p3_posx;
    logic [63:0] r_p3_ms, r_p3_ec44, r_p3_mc, r_p3_as;
    logic        r_p3_cneg, r_p3_sneg, r_p3_spos;
    t_pp         r_p4_y, r_p4_d;
    logic [41:0] r_p4_posx;
    logic [63:0] r_p4_mc, r_p4_as;
    logic        r_p4_cneg, r_p4_sneg, r_p4_spos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
        end else if (w_en) begin
            r_p1_v <= w_sc_valid;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_acme <= abs64(w_cme);
            r_p1_xneg <= w_cme[63];
            r_p1_ac   <= abs64(w_cos);
            r_p1_as   <= abs64(w_sin);
            r_p1_cneg <= w_cos[63];
            r_p1_sneg <= w_sin[63];
            r_p1_spos <= !w_sin[63] && (w_sin != '0);

            r_p2_x    <= mul64(64'(w_cfg.a), r_p1_acme);
            r_p2_ms   <= mul64(64'(w_cfg.m), r_p1_as);
            r_p2_ec   <= mul64(64'(w_cfg.e), r_p1_ac);
            r_p2_mc   <= mul64(64'(w_cfg.m), r_p1_ac);
            r_p2_as   <= r_p1_as;
            r_p2_xneg <= r_p1_xneg;
            r_p2_cneg <= r_p1_cneg;
            r_p2_sneg <= r_p1_sneg;
            r_p2_spos <= r_p1_spos;

            r_p3_posx <= 42'(sat_out(rnd_shr(pp_sum(r_p2_x), 60), r_p2_xneg, 42));
            r_p3_ms   <= rnd_shr(pp_sum(r_p2_ms), 60);
            r_p3_ec44 <= rnd_shr(pp_sum(r_p2_ec), 40);
            r_p3_mc   <= rnd_shr(pp_sum(r_p2_mc), 60);
            r_p3_as   <= r_p2_as;
            r_p3_cneg <= r_p2_cneg;
            r_p3_sneg <= r_p2_sneg;
            r_p3_spos <= r_p2_spos;

            r_p4_y    <= mul64(64'(w_cfg.a), r_p3_ms);
            r_p4_d    <= mul64(64'(w_cfg.a), r_p3_cneg ? (64'd1 << 44) + r_p3_ec44
                                                       : (64'd1 << 44) - r_p3_ec44);
            r_p4_posx <= r_p3_posx;
            r_p4_mc   <= r_p3_mc;
            r_p4_as   <= r_p3_as;
            r_p4_cneg <= r_p3_cneg;
            r_p4_sneg <= r_p3_sneg;
            r_p4_spos <= r_p3_spos;
        end
    end

    logic        r_vv [0:DIV_V_STEPS];
    logic [95:0] r_vd [0:DIV_V_STEPS];
    t_dv         r_vq [0:DIV_V_STEPS];
    t_vp         r_vp [0:DIV_V_STEPS];
    logic [95:0] w_d;
    logic [95:0] w_r0;

    assign w_d  = 96'(pp_sum(r_p4_d));
    assign w_r0 = 96'(w_cfg.num[102:63]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vv[0] <= 1'b0;
        end else if (w_en) begin
            r_vv[0] <= r_p4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vd[0]      <= w_d;
            r_vq[0].rem  <= w_r0;
            r_vq[0].q    <= '0;
            r_vp[0].posx <= r_p4_posx;
            r_vp[0].posy <= 42'(sat_out(rnd_shr(pp_sum(r_p4_y), 60), r_p4_sneg, 42));
            r_vp[0].as   <= r_p4_as;
            r_vp[0].mc   <= r_p4_mc;
            r_vp[0].spos <= r_p4_spos;
            r_vp[0].cneg <= r_p4_cneg;
            r_vp[0].cap  <= w_r0 >= w_d;
        end
    end

    for (genvar gi = 0; gi < DIV_V_STEPS; gi++) begin : g_vdiv
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vv[gi+1] <= 1'b0;
            end else if (w_en) begin
                r_vv[gi+1] <= r_vv[gi];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_vq[gi+1] <= div_step(r_vq[gi], r_vd[gi], w_cfg.num[DIV_V_STEPS-1-gi]);
                r_vd[gi+1] <= r_vd[gi];
                r_vp[gi+1] <= r_vp[gi];
            end
        end
    end

    logic        r_v1_v;
    t_pp         r_v1_x, r_v1_y;
    t_vp         r_v1_p;
    logic [63:0] w_v4;
    logic        w_inv;

    assign w_v4  = r_vp[DIV_V_STEPS].cap ? {1'b0, {63{1'b1}}}
                                         : {1'b0, r_vq[DIV_V_STEPS].q[62:0]};
    assign w_inv = (w_cfg.a == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1_v  <= 1'b0;
            o_valid <= 1'b0;
        end else if (w_en) begin
            r_v1_v  <= r_vv[DIV_V_STEPS];
            o_valid <= r_v1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v1_x    <= mul64(w_v4, r_vp[DIV_V_STEPS].as);
            r_v1_y    <= mul64(w_v4, r_vp[DIV_V_STEPS].mc);
            r_v1_p    <= r_vp[DIV_V_STEPS];
            o_pos_x   <= r_v1_p.posx;
            o_pos_y   <= r_v1_p.posy;
            o_invalid <= w_inv;
            if (w_inv) begin
                o_vel_x <= '0;
                o_vel_y <= '0;
            end else begin
                o_vel_x <= 40'(sat_out(rnd_shr(pp_sum(r_v1_x), 64), r_v1_p.spos, 40));
                o_vel_y <= 40'(sat_out(rnd_shr(pp_sum(r_v1_y), 64), r_v1_p.cneg, 40));
            end
        end
    end

    a_busy_blocks_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg.busy |-> o_stall)
        else $error("input accepted while configuration is being derived");

    a_write_restarts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> w_cfg.busy)
        else $error("register write did not restart the sequencer");

    a_invalid_zero_vel : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid) |-> (o_vel_x == '0 && o_vel_y == '0))
        else $error("velocity not zero for zero semimajor axis");

    a_stall_freezes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(w_sc_valid) && $stable(r_vv[DIV_V_STEPS]))
        else $error("pipeline moved during output stall");

endmodule

### rtl/pfs_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_cfg
// Configuration registers and a sequencer that derives sqrt(1-e^2) and the
// scaled speed numerator after reset and after every register write.
// ----------------------------------------------------------------------------
module pfs_cfg import pfs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [49:0] i_cfg_data,
    output t_cfg        o_cfg
);

    typedef enum logic [4:0] {
        CS_IDLE = 5'b00001,
        CS_MUL  = 5'b00010,
        CS_SUM  = 5'b00100,
        CS_SQM  = 5'b01000,
        CS_SQV  = 5'b10000
    } t_cst;

    localparam logic [5:0] LAST_STEP = 6'(SQ_STEPS - 1);

    t_cst         r_st;
    logic [49:0]  r_gm;
    logic [23:0]  r_e;
    logic [39:0]  r_a;
    logic [60:0]  r_m;
    logic [102:0] r_num;
    t_pp          r_pp;
    logic [127:0] r_rad;
    logic [127:0] r_radv;
    t_sq          r_sq;
    logic [5:0]   r_cnt;
    t_sq          n_sq;
    logic [48:0]  w_om;
    logic [72:0]  w_vnum;

    assign n_sq   = sqrt_step(r_sq, r_rad[127:126]);
    assign w_om   = (49'd1 << 48) - 49'(r_e) * 49'(r_e);
    assign w_vnum = 73'(n_sq.root) * MM_PER_M;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gm <= GM_RESET;
            r_e  <= '0;
            r_a  <= SMA_RESET;
            r_st <= CS_MUL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GRAV_PARAM: r_gm <= i_cfg_data;
                REG_ECC:        r_e  <= i_cfg_data[23:0];
                REG_SMA:        r_a  <= i_cfg_data[39:0];
                default:        ;
            endcase
            r_st <= CS_MUL;
        end else begin
            unique case (r_st)
                CS_MUL: begin
                    r_pp <= mul64(64'(r_gm), 64'(r_a));
                    r_st <= CS_SUM;
                end
                CS_SUM: begin
                    r_radv <= pp_sum(r_pp) << 36;
                    r_rad  <= {7'b0, w_om, 72'b0};
                    r_sq   <= '0;
                    r_cnt  <= '0;
                    r_st   <= CS_SQM;
                end
                CS_SQM: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == LAST_STEP) begin
                        r_m   <= n_sq.root[60:0];
                        r_sq  <= '0;
                        r_rad <= r_radv;
                        r_st  <= CS_SQV;
                    end else begin
                        r_sq  <= n_sq;
                        r_rad <= {r_rad[125:0], 2'b00};
                    end
                end
                CS_SQV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == LAST_STEP) begin
                        r_num <= {w_vnum, 30'b0};
                        r_st  <= CS_IDLE;
                    end else begin
                        r_sq  <= n_sq;
                        r_rad <= {r_rad[125:0], 2'b00};
                    end
                end
                CS_IDLE: ;
                default: r_st <= CS_IDLE;
            endcase
        end
    end

    assign o_cfg.busy = (r_st != CS_IDLE);
    assign o_cfg.a    = r_a;
    assign o_cfg.e    = r_e;
    assign o_cfg.m    = r_m;
    assign o_cfg.num  = r_num;

endmodule

### rtl/pfs_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_sincos
// Pipelined CORDIC sine and cosine in Q60 with length normalization by a
// pipelined square root and two pipelined dividers.
// ----------------------------------------------------------------------------
module pfs_sincos import pfs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [31:0]        i_ang,
    output logic               o_valid,
    output logic signed [63:0] o_cos,
    output logic signed [63:0] o_sin
);

    typedef struct packed {
        logic [63:0] mx;
        logic [63:0] my;
        logic        xneg;
        logic        yneg;
        logic [1:0]  quad;
    } t_nv;

    logic        r_a1_v;
    logic [1:0]  r_a1_q;
    logic [59:0] r_a1_hi;
    logic [61:0] r_a1_lo;
    logic [92:0] w_zs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1_v <= 1'b0;
        end else if (i_en) begin
            r_a1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1_q  <= i_ang[31:30];
            r_a1_hi <= 60'(i_ang[29:0]) * 60'(PI_Q60[61:32]);
            r_a1_lo <= 62'(i_ang[29:0]) * 62'(PI_Q60[31:0]);
        end
    end

    assign w_zs = 93'({r_a1_hi, 32'b0}) + 93'(r_a1_lo) + (93'd1 << 30);

    logic               r_cv [0:CORDIC_STAGES];
    logic signed [63:0] r_cx [0:CORDIC_STAGES];
    logic signed [63:0] r_cy [0:CORDIC_STAGES];
    logic signed [63:0] r_cz [0:CORDIC_STAGES];
    logic [1:0]         r_cq [0:CORDIC_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (i_en) begin
            r_cv[0] <= r_a1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0] <= 64'sd1 <<< 58;
            r_cy[0] <= '0;
            r_cz[0] <= $signed({2'b00, w_zs[92:31]});
            r_cq[0] <= r_a1_q;
        end
    end

    for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cordic
        localparam logic signed [63:0] ATAN = atan_q60(gi);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[gi+1] <= 1'b0;
            end else if (i_en) begin
                r_cv[gi+1] <= r_cv[gi];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cq[gi+1] <= r_cq[gi];
                if (r_cz[gi][63]) begin
                    r_cx[gi+1] <= r_cx[gi] + (r_cy[gi] >>> gi);
                    r_cy[gi+1] <= r_cy[gi] - (r_cx[gi] >>> gi);
                    r_cz[gi+1] <= r_cz[gi] + ATAN;
                end else begin
                    r_cx[gi+1] <= r_cx[gi] - (r_cy[gi] >>> gi);
                    r_cy[gi+1] <= r_cy[gi] + (r_cx[gi] >>> gi);
                    r_cz[gi+1] <= r_cz[gi] - ATAN;
                end
            end
        end
    end

    logic r_s1_v;
    t_nv  r_s1_p;
    t_pp  r_s1_px;
    t_pp  r_s1_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_en) begin
            r_s1_v <= r_cv[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_p.mx   <= abs64(r_cx[CORDIC_STAGES]);
            r_s1_p.my   <= abs64(r_cy[CORDIC_STAGES]);
            r_s1_p.xneg <= r_cx[CORDIC_STAGES][63];
            r_s1_p.yneg <= r_cy[CORDIC_STAGES][63];
            r_s1_p.quad <= r_cq[CORDIC_STAGES];
            r_s1_px     <= mul64(abs64(r_cx[CORDIC_STAGES]), abs64(r_cx[CORDIC_STAGES]));
            r_s1_py     <= mul64(abs64(r_cy[CORDIC_STAGES]), abs64(r_cy[CORDIC_STAGES]));
        end
    end

    logic         r_qv   [0:SQ_STEPS];
    logic [127:0] r_qrad [0:SQ_STEPS];
    t_sq          r_qs   [0:SQ_STEPS];
    t_nv          r_qp   [0:SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv[0] <= 1'b0;
        end else if (i_en) begin
            r_qv[0] <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qrad[0] <= pp_sum(r_s1_px) + pp_sum(r_s1_py);
            r_qs[0]   <= '0;
            r_qp[0]   <= r_s1_p;
        end
    end

    for (genvar gi = 0; gi < SQ_STEPS; gi++) begin : g_sqrt
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qv[gi+1] <= 1'b0;
            end else if (i_en) begin
                r_qv[gi+1] <= r_qv[gi];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_qs[gi+1]   <= sqrt_step(r_qs[gi], r_qrad[gi][127:126]);
                r_qrad[gi+1] <= {r_qrad[gi][125:0], 2'b00};
                r_qp[gi+1]   <= r_qp[gi];
            end
        end
    end

    logic        r_dv   [0:DIV_U_STEPS];
    logic [95:0] r_dlen [0:DIV_U_STEPS];
    t_dv         r_dx   [0:DIV_U_STEPS];
    t_dv         r_dy   [0:DIV_U_STEPS];
    logic        r_dcx  [0:DIV_U_STEPS];
    logic        r_dcy  [0:DIV_U_STEPS];
    t_nv         r_dp   [0:DIV_U_STEPS];
    logic [63:0] w_len;

    assign w_len = (r_qs[SQ_STEPS].root == '0) ? 64'd1 : r_qs[SQ_STEPS].root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (i_en) begin
            r_dv[0] <= r_qv[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dlen[0]   <= 96'(w_len);
            r_dx[0].rem <= 96'(r_qp[SQ_STEPS].mx >> 1);
            r_dx[0].q   <= '0;
            r_dy[0].rem <= 96'(r_qp[SQ_STEPS].my >> 1);
            r_dy[0].q   <= '0;
            r_dcx[0]    <= (r_qp[SQ_STEPS].mx >> 1) >= w_len;
            r_dcy[0]    <= (r_qp[SQ_STEPS].my >> 1) >= w_len;
            r_dp[0]     <= r_qp[SQ_STEPS];
        end
    end

    for (genvar gi = 0; gi < DIV_U_STEPS; gi++) begin : g_udiv
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[gi+1] <= 1'b0;
            end else if (i_en) begin
                r_dv[gi+1] <= r_dv[gi];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dx[gi+1]   <= div_step(r_dx[gi], r_dlen[gi],
                                         (gi == 0) ? r_dp[gi].mx[0] : 1'b0);
                r_dy[gi+1]   <= div_step(r_dy[gi], r_dlen[gi],
                                         (gi == 0) ? r_dp[gi].my[0] : 1'b0);
                r_dlen[gi+1] <= r_dlen[gi];
                r_dcx[gi+1]  <= r_dcx[gi];
                r_dcy[gi+1]  <= r_dcy[gi];
                r_dp[gi+1]   <= r_dp[gi];
            end
        end
    end

    logic [63:0]        w_cm;
    logic [63:0]        w_sm;
    logic signed [63:0] w_c0;
    logic signed [63:0] w_s0;

    assign w_cm = (r_dcx[DIV_U_STEPS] || r_dx[DIV_U_STEPS].q > ONE_Q60)
                  ? ONE_Q60 : r_dx[DIV_U_STEPS].q;
    assign w_sm = (r_dcy[DIV_U_STEPS] || r_dy[DIV_U_STEPS].q > ONE_Q60)
                  ? ONE_Q60 : r_dy[DIV_U_STEPS].q;
    assign w_c0 = r_dp[DIV_U_STEPS].xneg ? -$signed(w_cm) : $signed(w_cm);
    assign w_s0 = r_dp[DIV_U_STEPS].yneg ? -$signed(w_sm) : $signed(w_sm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_dv[DIV_U_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_dp[DIV_U_STEPS].quad)
                2'd0: begin
                    o_cos <= w_c0;
                    o_sin <= w_s0;
                end
                2'd1: begin
                    o_cos <= -w_s0;
                    o_sin <= w_c0;
                end
                2'd2: begin
                    o_cos <= -w_c0;
                    o_sin <= -w_s0;
                end
                default: begin
                    o_cos <= w_s0;
                    o_sin <= -w_c0;
                end
            endcase
        end
    end

endmodule
